// File: rtl/core/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
// No dependencies; compile first.
package ffha_pkg;

	// operation codes of the request word
	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_FIT    = 3'd1,
		ST_ZERO      = 3'd2,
		ST_OUTSIDE   = 3'd3,
		ST_DOUBLE    = 3'd4,
		ST_NOT_START = 3'd5,
		ST_RSVD6     = 3'd6,
		ST_RSVD7     = 3'd7
	} status_t;

	localparam int BYTES_W = 18;  // request and offset width
	localparam int COUNT_W = 19;  // byte counter width
	localparam int NEED_W  = 15;  // granules needed for the largest request
	localparam int MIN_SPLIT_GRANULES = 2;  // 32 bytes left over before a split

endpackage

// File: rtl/core/ffha_req_if.sv
// Request channel of the allocator: valid/ready plus the request word.
// Depends on ffha_pkg.
interface ffha_req_if;
	import ffha_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          op;
	logic [BYTES_W-1:0]  request_bytes;
	logic [BYTES_W-1:0]  release_offset;

	modport source (output valid, op, request_bytes, release_offset, input ready);
	modport sink   (input valid, op, request_bytes, release_offset, output ready);
endinterface

// File: rtl/core/ffha_rsp_if.sv
// Response channel of the allocator: valid/ready plus the result word.
// Depends on ffha_pkg.
interface ffha_rsp_if;
	import ffha_pkg::*;
	logic                valid;
	logic                ready;
	logic [2:0]          status;
	logic [BYTES_W-1:0]  user_offset;
	logic [COUNT_W-1:0]  bytes_in_use;
	logic [COUNT_W-1:0]  largest_free_bytes;

	modport source (output valid, status, user_offset, bytes_in_use, largest_free_bytes,
		input ready);
	modport sink   (input valid, status, user_offset, bytes_in_use, largest_free_bytes,
		output ready);
endinterface

// File: rtl/core/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write, and read the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/core/ffha_next.sv
// Block-walk unit: start granule of the block after a given block.
// No dependencies; shared by allocate, free and query walks.
module ffha_next #(
	parameter int POOL_GRANULES = 16384
) (
	input  logic [$clog2(POOL_GRANULES):0] idx,
	input  logic [$clog2(POOL_GRANULES):0] size,
	output logic [$clog2(POOL_GRANULES):0] nxt
);
	localparam int SZW = $clog2(POOL_GRANULES) + 1;
	localparam logic [SZW:0] POOL_END = (SZW+1)'(POOL_GRANULES);

	logic [SZW:0] sum;

	// step over the block; a zero size or overrun ends the walk
	always_comb begin
		sum = {1'b0, idx} + {1'b0, size};
		if (size == '0 || sum >= POOL_END) begin
			nxt = SZW'(POOL_GRANULES);
		end else begin
			nxt = sum[SZW-1:0];
		end
	end
endmodule

// File: rtl/core/first_fit_heap_allocator_core.sv
// First-fit heap allocator core over a pool of 16-byte granules; one word at a time.
// Reset is asynchronous; a clearing pass over every header then runs before the first word.
// Allocate walks the headers from the start and writes the split-off remainder when splitting;
// query walks every block; free checks the header, walks the blocks before the freed one and
// merges with free neighbours; zero size, outside pool, misaligned or unused op skip the walk.
// Each word is taken only in idle; a result held by the sink holds the sequencer.
// Depends on ffha_pkg, ffha_req_if, ffha_rsp_if, ffha_ram, ffha_next.
module first_fit_heap_allocator_core #(
	parameter int POOL_GRANULES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	ffha_req_if.sink    req_ch,
	ffha_rsp_if.source  rsp_ch
);
	import ffha_pkg::*;

	localparam int AW  = $clog2(POOL_GRANULES);
	localparam int SZW = AW + 1;
	localparam int EW  = SZW + 2;
	localparam logic [SZW-1:0] POOL_END  = SZW'(POOL_GRANULES);
	localparam logic [AW-1:0]  LAST_IDX  = AW'(POOL_GRANULES - 1);
	localparam logic [20:0]    POOL_BYTES = 21'(POOL_GRANULES * 16);

	typedef enum logic [18:0] {
		S_CLR   = 19'h00001,
		S_IDLE  = 19'h00002,
		S_A_RD  = 19'h00004,
		S_A_EV  = 19'h00008,
		S_A_SPL = 19'h00010,
		S_A_TAK = 19'h00020,
		S_F_CRD = 19'h00040,
		S_F_CEV = 19'h00080,
		S_F_WRD = 19'h00100,
		S_F_WEV = 19'h00200,
		S_F_PM  = 19'h00400,
		S_F_PZ  = 19'h00800,
		S_F_NX  = 19'h01000,
		S_F_NRD = 19'h02000,
		S_F_NEV = 19'h04000,
		S_F_NZ  = 19'h08000,
		S_Q_RD  = 19'h10000,
		S_Q_EV  = 19'h20000,
		S_DONE  = 19'h40000
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	logic [SZW-1:0]     i_q, b_q, bs_q, prev_q, prev_sz_q, best_q;
	logic               prev_free_q;
	logic [NEED_W-1:0]  need_q;
	logic [2:0]         status_q;
	logic [BYTES_W-1:0] user_q;
	logic [COUNT_W-1:0] used_q, largest_q;
	logic               out_valid_q;
	logic [2:0]         out_status_q;
	logic [BYTES_W-1:0] out_user_q;
	logic [COUNT_W-1:0] out_used_q, out_largest_q;

	// RAM and walk-unit hookup
	logic               we;
	logic [AW-1:0]      waddr;
	logic [EW-1:0]      wdata, rdata;
	logic [SZW-1:0]     walk_idx, walk_size, nxt;
	logic               h_start, h_alloc, h_free;
	logic [SZW-1:0]     h_size;
	logic [17:0]        rem;
	logic               fits;
	logic [BYTES_W-1:0] gofs;

	ffha_ram #(.WIDTH(EW), .DEPTH(POOL_GRANULES)) u_hdr (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (i_q[AW-1:0]),
		.rdata (rdata)
	);

	ffha_next #(.POOL_GRANULES(POOL_GRANULES)) u_next (
		.idx  (walk_idx),
		.size (walk_size),
		.nxt  (nxt)
	);

	assign h_start = rdata[EW-1];
	assign h_alloc = rdata[EW-2];
	assign h_size  = rdata[SZW-1:0];
	assign h_free  = h_start && !h_alloc;
	assign rem     = 18'(h_size) - 18'(need_q);
	assign fits    = h_free && (18'(h_size) >= 18'(need_q));
	assign gofs    = req_ch.release_offset - BYTES_W'(16);

	// walk from the merged block in the free tail, else from the header just read
	always_comb begin
		if (state_q == S_F_NX) begin
			walk_idx  = b_q;
			walk_size = bs_q;
		end else begin
			walk_idx  = i_q;
			walk_size = h_size;
		end
	end

	// header writes
	always_comb begin
		we    = 1'b0;
		waddr = i_q[AW-1:0];
		wdata = '0;
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = (clr_q == '0) ? {2'b10, POOL_END} : '0;
			end
			S_A_EV: begin
				if (fits && rem < 18'(MIN_SPLIT_GRANULES)) begin
					we    = 1'b1;
					wdata = {2'b11, h_size};
				end
			end
			S_A_SPL: begin
				we    = 1'b1;
				waddr = AW'(i_q + SZW'(need_q));
				wdata = {2'b10, bs_q};
			end
			S_A_TAK: begin
				we    = 1'b1;
				wdata = {2'b11, SZW'(need_q)};
			end
			S_F_CEV: begin
				if (h_start && h_alloc) begin
					we    = 1'b1;
					waddr = b_q[AW-1:0];
					wdata = {2'b10, h_size};
				end
			end
			S_F_PM: begin
				if (prev_q < b_q && prev_free_q && i_q == b_q) begin
					we    = 1'b1;
					waddr = prev_q[AW-1:0];
					wdata = {2'b10, SZW'(prev_sz_q + bs_q)};
				end
			end
			S_F_PZ, S_F_NZ: begin
				we    = 1'b1;
				wdata = '0;
			end
			S_F_NEV: begin
				if (h_free) begin
					we    = 1'b1;
					waddr = b_q[AW-1:0];
					wdata = {2'b10, SZW'(bs_q + h_size)};
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result word, else drop the one taken by the sink
			if (state_q == S_DONE && (!out_valid_q || rsp_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_ch.valid) begin
						status_q  <= ST_OK;
						user_q    <= '0;
						largest_q <= '0;
						i_q       <= '0;
						best_q    <= '0;
						need_q    <= NEED_W'((19'(req_ch.request_bytes) + 19'd31) >> 4);
						case (req_ch.op)
							OP_ALLOC: begin
								if (req_ch.request_bytes == '0) begin
									status_q <= ST_ZERO;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_A_RD;
								end
							end
							OP_FREE: begin
								if (req_ch.release_offset < BYTES_W'(16) ||
										{3'b000, gofs} >= POOL_BYTES) begin
									status_q <= ST_OUTSIDE;
									state_q  <= S_DONE;
								end else if (gofs[3:0] != 4'd0) begin
									status_q <= ST_NOT_START;
									state_q  <= S_DONE;
								end else begin
									b_q     <= SZW'(gofs[BYTES_W-1:4]);
									i_q     <= SZW'(gofs[BYTES_W-1:4]);
									state_q <= S_F_CRD;
								end
							end
							OP_QUERY: begin
								state_q <= S_Q_RD;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				// allocate: walk for the first free block that fits
				S_A_RD: begin
					state_q <= S_A_EV;
				end
				S_A_EV: begin
					if (fits) begin
						user_q <= BYTES_W'({i_q, 4'b0000}) + BYTES_W'(16);
						if (rem >= 18'(MIN_SPLIT_GRANULES)) begin
							bs_q    <= SZW'(rem);
							state_q <= S_A_SPL;
						end else begin
							used_q  <= used_q + COUNT_W'({h_size, 4'b0000});
							state_q <= S_DONE;
						end
					end else if (nxt == POOL_END) begin
						status_q <= ST_NO_FIT;
						state_q  <= S_DONE;
					end else begin
						i_q     <= nxt;
						state_q <= S_A_RD;
					end
				end
				S_A_SPL: begin
					state_q <= S_A_TAK;
				end
				S_A_TAK: begin
					used_q  <= used_q + COUNT_W'({need_q, 4'b0000});
					state_q <= S_DONE;
				end
				// free: check the header, release it, then find the previous block
				S_F_CRD: begin
					state_q <= S_F_CEV;
				end
				S_F_CEV: begin
					if (!h_start) begin
						status_q <= ST_NOT_START;
						state_q  <= S_DONE;
					end else if (!h_alloc) begin
						status_q <= ST_DOUBLE;
						state_q  <= S_DONE;
					end else begin
						bs_q        <= h_size;
						used_q      <= used_q - COUNT_W'({h_size, 4'b0000});
						i_q         <= '0;
						prev_q      <= POOL_END;
						prev_free_q <= 1'b0;
						state_q     <= S_F_WRD;
					end
				end
				S_F_WRD: begin
					state_q <= (i_q < b_q) ? S_F_WEV : S_F_PM;
				end
				S_F_WEV: begin
					prev_q      <= i_q;
					prev_sz_q   <= h_size;
					prev_free_q <= h_free;
					i_q         <= nxt;
					state_q     <= S_F_WRD;
				end
				S_F_PM: begin
					if (prev_q < b_q && prev_free_q && i_q == b_q) begin
						bs_q    <= SZW'(prev_sz_q + bs_q);
						b_q     <= prev_q;
						state_q <= S_F_PZ;
					end else begin
						state_q <= S_F_NX;
					end
				end
				S_F_PZ: begin
					state_q <= S_F_NX;
				end
				// free: absorb a free block that follows
				S_F_NX: begin
					if (nxt == POOL_END) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= nxt;
						state_q <= S_F_NRD;
					end
				end
				S_F_NRD: begin
					state_q <= S_F_NEV;
				end
				S_F_NEV: begin
					state_q <= h_free ? S_F_NZ : S_DONE;
				end
				S_F_NZ: begin
					state_q <= S_DONE;
				end
				// query: track the largest free block
				S_Q_RD: begin
					state_q <= S_Q_EV;
				end
				S_Q_EV: begin
					if (nxt == POOL_END) begin
						if (h_free && h_size > best_q) begin
							largest_q <= COUNT_W'({h_size, 4'b0000});
						end else begin
							largest_q <= COUNT_W'({best_q, 4'b0000});
						end
						state_q <= S_DONE;
					end else begin
						if (h_free && h_size > best_q) begin
							best_q <= h_size;
						end
						i_q     <= nxt;
						state_q <= S_Q_RD;
					end
				end
				// hand the result word to the output register
				S_DONE: begin
					if (!out_valid_q || rsp_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || rsp_ch.ready)) begin
			out_status_q  <= status_q;
			out_user_q    <= user_q;
			out_used_q    <= used_q;
			out_largest_q <= largest_q;
		end
	end

	assign req_ch.ready              = (state_q == S_IDLE);
	assign rsp_ch.valid              = out_valid_q;
	assign rsp_ch.status             = out_status_q;
	assign rsp_ch.user_offset        = out_user_q;
	assign rsp_ch.bytes_in_use       = out_used_q;
	assign rsp_ch.largest_free_bytes = out_largest_q;
endmodule

// File: sim/first_fit_heap_allocator_core_tb.sv
// Self-checking testbench for the first-fit heap allocator core: directed and random words
// with a header-level predictor of the pool, random idling on both channels.
// Depends on ffha_pkg, ffha_req_if, ffha_rsp_if and the allocator core.
module first_fit_heap_allocator_core_tb;
	import ffha_pkg::*;

	localparam int POOL = 16384;
	localparam int GRAN = 16;

	typedef struct {
		op_t               op;
		logic [BYTES_W-1:0] req;
		logic [BYTES_W-1:0] rel;
		bit                drain;
	} heap_cmd_t;

	typedef struct {
		status_t            st;
		logic [BYTES_W-1:0] user;
		logic [COUNT_W-1:0] used;
		logic [COUNT_W-1:0] largest;
	} heap_rsp_t;

	logic clk;
	logic arst_n;

	ffha_req_if req_ch();
	ffha_rsp_if rsp_ch();

	first_fit_heap_allocator_core #(.POOL_GRANULES(POOL)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req_ch),
		.rsp_ch(rsp_ch)
	);

	// pool image: one header per granule
	bit                 hdr_start [POOL];
	bit                 hdr_taken [POOL];
	int unsigned        hdr_gran  [POOL];
	logic [COUNT_W-1:0] used_bytes;

	heap_cmd_t cmd_q[$];
	heap_rsp_t pend_q[$];
	heap_rsp_t heap_rsp_q[$];
	int unsigned live_offsets[$];
	int unsigned freed_offsets[$];

	int errors, words_sent, results_seen, alloc_ok, free_ok, peak_live;
	int tx_gap, rx_gap, hold_left;
	bit hold_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int unsigned next_hdr(int unsigned i);
		int unsigned s;
		s = hdr_gran[i];
		if (s == 0 || s >= POOL - i)
			return POOL;
		return i + s;
	endfunction

	function automatic bit is_free_blk(int unsigned i);
		return hdr_start[i] && !hdr_taken[i];
	endfunction

	function automatic void set_hdr(int unsigned i, int s, int t, int unsigned g);
		hdr_start[i] = (s != 0);
		hdr_taken[i] = (t != 0);
		hdr_gran[i]  = g;
	endfunction

	function automatic status_t model_alloc(int unsigned req, output int unsigned user);
		int unsigned need, i, bs;
		user = 0;
		if (req == 0)
			return ST_ZERO;
		need = (req + 16 + GRAN - 1) / GRAN;
		i = 0;
		while (i < POOL) begin
			bs = hdr_gran[i];
			if (is_free_blk(i) && bs >= need) begin
				// split only when a usable remainder is left
				if ((bs - need) * GRAN >= 32) begin
					set_hdr(i + need, 1, 0, bs - need);
					set_hdr(i, 1, 1, need);
					used_bytes = COUNT_W'(used_bytes + need * GRAN);
				end else begin
					hdr_taken[i] = 1'b1;
					used_bytes = COUNT_W'(used_bytes + bs * GRAN);
				end
				user = i * GRAN + 16;
				return ST_OK;
			end
			i = next_hdr(i);
		end
		return ST_NO_FIT;
	endfunction

	function automatic status_t model_free(int unsigned off);
		int unsigned g, b, bs, prev, cur, nx;
		if (off < 16 || off - 16 >= POOL * GRAN)
			return ST_OUTSIDE;
		g = off - 16;
		if (g % GRAN != 0)
			return ST_NOT_START;
		b = g / GRAN;
		if (!hdr_start[b])
			return ST_NOT_START;
		if (!hdr_taken[b])
			return ST_DOUBLE;
		bs = hdr_gran[b];
		used_bytes = COUNT_W'(used_bytes - bs * GRAN);
		hdr_taken[b] = 1'b0;
		// merge with the free block just before
		prev = POOL;
		cur = 0;
		while (cur < b) begin
			prev = cur;
			cur = next_hdr(cur);
		end
		if (prev < b && is_free_blk(prev) && next_hdr(prev) == b) begin
			hdr_gran[prev] = hdr_gran[prev] + bs;
			set_hdr(b, 0, 0, 0);
			b = prev;
		end
		// merge with the free block just after
		nx = next_hdr(b);
		if (nx < POOL && is_free_blk(nx)) begin
			hdr_gran[b] = hdr_gran[b] + hdr_gran[nx];
			set_hdr(nx, 0, 0, 0);
		end
		return ST_OK;
	endfunction

	function automatic int unsigned model_largest();
		int unsigned best, i;
		best = 0;
		i = 0;
		while (i < POOL) begin
			if (is_free_blk(i) && hdr_gran[i] > best)
				best = hdr_gran[i];
			i = next_hdr(i);
		end
		return best * GRAN;
	endfunction

	// predict the result of one word, queue both and track live user areas
	function automatic void push_cmd(op_t op, int unsigned req, int unsigned rel, int drain);
		heap_cmd_t c;
		heap_rsp_t r;
		int unsigned user;
		int idx[$];
		c.op = op; c.req = BYTES_W'(req); c.rel = BYTES_W'(rel); c.drain = (drain != 0);
		r.st = ST_OK; r.user = '0; r.largest = '0;
		case (op)
			OP_ALLOC: begin
				r.st = model_alloc(c.req, user);
				r.user = BYTES_W'(user);
				if (r.st == ST_OK) begin
					live_offsets.push_back(user);
					alloc_ok++;
				end
			end
			OP_FREE: begin
				r.st = model_free(c.rel);
				if (r.st == ST_OK) begin
					idx = live_offsets.find_first_index(x) with (x == c.rel);
					if (idx.size() > 0)
						live_offsets.delete(idx[0]);
					freed_offsets.push_back(c.rel);
					free_ok++;
				end
			end
			OP_QUERY: r.largest = COUNT_W'(model_largest());
			default: ;
		endcase
		r.used = used_bytes;
		if (live_offsets.size() > peak_live)
			peak_live = live_offsets.size();
		cmd_q.push_back(c);
		pend_q.push_back(r);
	endfunction

	function automatic int unsigned rand_alloc_size();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 70)
			return $urandom_range(1, 200);
		if (k < 95)
			return $urandom_range(1, 4096);
		return $urandom_range(1, 262143);
	endfunction

	function automatic int unsigned rand_bad_offset();
		int unsigned k;
		k = $urandom_range(0, 3);
		if (k == 0)
			return $urandom_range(0, 15);
		if (k == 1 && freed_offsets.size() > 0)
			return freed_offsets[$urandom_range(0, freed_offsets.size() - 1)];
		if (k == 2 && live_offsets.size() > 0)
			return live_offsets[$urandom_range(0, live_offsets.size() - 1)] +
				$urandom_range(1, 40);
		return $urandom_range(0, 262143);
	endfunction

	// driver: offer queued words, move their prediction on acceptance
	always @(posedge clk or negedge arst_n) begin
		bit offering;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= OP_NONE;
			req_ch.request_bytes <= '0;
			req_ch.release_offset <= '0;
			tx_gap = 0;
		end else begin
			offering = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				heap_rsp_q.push_back(pend_q.pop_front());
				void'(cmd_q.pop_front());
				words_sent++;
				offering = 1'b0;
				tx_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
			end
			if (!offering) begin
				if (tx_gap > 0) begin
					tx_gap--;
					req_ch.valid <= 1'b0;
				end else if (cmd_q.size() > 0 &&
						!(cmd_q[0].drain && heap_rsp_q.size() > 0)) begin
					req_ch.valid <= 1'b1;
					req_ch.op <= cmd_q[0].op;
					req_ch.request_bytes <= cmd_q[0].req;
					req_ch.release_offset <= cmd_q[0].rel;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: stall at random, hold off once for a long stretch, check every word
	always @(posedge clk or negedge arst_n) begin
		heap_rsp_t e;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_gap = 0;
			hold_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (heap_rsp_q.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					e = heap_rsp_q.pop_front();
					if (rsp_ch.status !== e.st) begin
						$error("status exp %0d got %0d", e.st, rsp_ch.status);
						errors++;
					end
					if (rsp_ch.user_offset !== e.user) begin
						$error("user_offset exp %0d got %0d", e.user, rsp_ch.user_offset);
						errors++;
					end
					if (rsp_ch.bytes_in_use !== e.used) begin
						$error("bytes_in_use exp %0d got %0d", e.used, rsp_ch.bytes_in_use);
						errors++;
					end
					if (rsp_ch.largest_free_bytes !== e.largest) begin
						$error("largest_free_bytes exp %0d got %0d", e.largest,
							rsp_ch.largest_free_bytes);
						errors++;
					end
				end
				rx_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
				if (results_seen == 150 && !hold_done) begin
					hold_done = 1'b1;
					hold_left = 600;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned k;
		arst_n = 1'b0;
		for (int i = 0; i < POOL; i++)
			set_hdr(i, 0, 0, 0);
		set_hdr(0, 1, 0, POOL);
		used_bytes = '0;

		// directed: limits, every status, merges on both sides
		push_cmd(OP_ALLOC, 0, 0, 0);
		push_cmd(OP_ALLOC, 262143, 0, 0);
		push_cmd(OP_ALLOC, 262128, 0, 0);
		push_cmd(OP_QUERY, 0, 0, 0);
		push_cmd(OP_ALLOC, 1, 0, 0);
		push_cmd(OP_FREE, 0, 16, 0);
		push_cmd(OP_FREE, 0, 16, 0);
		push_cmd(OP_FREE, 0, 0, 0);
		push_cmd(OP_FREE, 0, 15, 0);
		push_cmd(OP_FREE, 0, 17, 0);
		push_cmd(OP_FREE, 0, 262143, 0);
		push_cmd(OP_FREE, 0, 262128, 0);
		push_cmd(OP_NONE, 262143, 262143, 0);
		push_cmd(OP_ALLOC, 1, 0, 0);
		push_cmd(OP_ALLOC, 16, 0, 0);
		push_cmd(OP_ALLOC, 100, 0, 0);
		push_cmd(OP_ALLOC, 200, 0, 0);
		push_cmd(OP_FREE, 0, 16, 0);
		push_cmd(OP_FREE, 0, 48, 0);
		push_cmd(OP_FREE, 0, 48, 0);
		push_cmd(OP_FREE, 0, 224, 0);
		push_cmd(OP_FREE, 0, 80, 0);
		push_cmd(OP_QUERY, 0, 0, 0);
		push_cmd(OP_ALLOC, 262112, 0, 0);
		push_cmd(OP_FREE, 0, 16, 0);

		// random: mostly alloc/free of live areas, some noise
		for (int n = 0; n < 500; n++) begin
			k = $urandom_range(0, 99);
			if (n == 250)
				push_cmd(OP_QUERY, $urandom, $urandom, 1);
			else if (k < 10)
				push_cmd(OP_QUERY, $urandom, $urandom, 0);
			else if (k < 12)
				push_cmd(OP_NONE, $urandom, $urandom, 0);
			else if (k < 15)
				push_cmd(OP_ALLOC, 0, $urandom, 0);
			else if (k < 25)
				push_cmd(OP_FREE, $urandom, rand_bad_offset(), 0);
			else if (live_offsets.size() > 0 && (k < 55 || live_offsets.size() > 80))
				push_cmd(OP_FREE, $urandom,
					live_offsets[$urandom_range(0, live_offsets.size() - 1)], 0);
			else
				push_cmd(OP_ALLOC, rand_alloc_size(), $urandom, 0);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() > 0 || heap_rsp_q.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("%0d words sent, %0d results checked: %0d allocations and %0d frees succeeded,",
			words_sent, results_seen, alloc_ok, free_ok);
		$display("up to %0d user areas live at once", peak_live);
		if (errors == 0 && heap_rsp_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_req_if.sv
rtl/core/ffha_rsp_if.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_next.sv
rtl/core/first_fit_heap_allocator_core.sv
sim/first_fit_heap_allocator_core_tb.sv
